// ----- design/fpc_pkg.sv -----
// ----------------------------------------------------------------------------
// fpc_pkg: shared types, codes and the CRC step for the frame parser.
// Holds the request and result structs, the field codes and the byte-wise
// CRC-16/MODBUS update used on the header, length and payload line bytes.
// ----------------------------------------------------------------------------
package fpc_pkg;

    // Storage depth of the payload memory.
    localparam int FPC_MAX_PAYLOAD = 256;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 1'b1;
    localparam int CFG_DATA_W = 9;

    // Register reset values.
    localparam logic [7:0] START_BYTE_RST = 8'd35;
    localparam logic [8:0] MAX_LEN_RST    = 9'd256;

    // Input action codes.
    localparam logic ACT_RX   = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Result kind codes.
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // CRC-16/MODBUS constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Number of header bytes kept ahead of the length field.
    localparam int HDR_BYTES = 3;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } fpc_in_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] dest_addr;
        logic [7:0] source_id;
        logic [7:0] function_code;
        logic [8:0] payload_len;
        logic [7:0] read_data;
    } fpc_out_t;

    // One byte of reflected CRC-16 update, unrolled over the eight bits.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- design/fpc_ram.sv -----
// ----------------------------------------------------------------------------
// fpc_ram: generic single-port-write, single-port-read RAM.
// One write and one registered read per cycle; read data holds between reads.
// ----------------------------------------------------------------------------
module fpc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/frame_parser_crc16_unit.sv -----
// ----------------------------------------------------------------------------
// frame_parser_crc16_unit: byte-serial deframer with CRC-16/MODBUS check.
// Parses start byte, header, little-endian length, payload and CRC; keeps
// the payload in a RAM that requests can read back by index.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                      Direction  Moves
//  -------   --------------------------   ---------  -------------------------
//  in        in_valid, in_stall, in_data   sink       one byte or read request
//  out       out_valid, out_stall, out_data source    frame or read-data result
//  cfg       cfg_we, cfg_index, cfg_data   sink       register write
//
//  One request is accepted every cycle while in_stall is low. A result goes
//  through the result stage (payload RAM read), then the output register.
//  Reset clears the parse state; the payload RAM is not cleared and an entry
//  reads back only after a frame has written it. in_stall rises only when the
//  result stage and the output register are both full and out_stall is high.
//
module frame_parser_crc16_unit
    import fpc_pkg::*;
#(
    parameter int MAX_PAYLOAD = FPC_MAX_PAYLOAD
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  fpc_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output fpc_out_t              out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    // Parse phase codes.
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_CRC    = 2'd3;

    // Configuration registers.
    logic [7:0] start_byte_reg;
    logic [8:0] max_len_reg;

    // Parse state.
    logic [1:0]  phase_reg, phase_next;
    logic [8:0]  count_reg, count_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [7:0]  hdr_reg [HDR_BYTES];
    logic [7:0]  hdr_next [HDR_BYTES];

    // Result stage (waits for the RAM read data) and output register.
    logic        s1_valid_reg;
    logic        s1_kind_reg;
    logic        s1_in_range_reg;
    logic [7:0]  s1_dest_reg;
    logic [7:0]  s1_src_reg;
    logic [7:0]  s1_func_reg;
    logic [8:0]  s1_len_reg;
    logic        out_valid_reg;
    fpc_out_t    out_data_reg;

    logic        in_acc;
    logic        is_rx;
    logic        is_read;
    logic        good_frame;
    logic        s2_free;
    logic        s1_advance;
    logic [16:0] limit;
    logic [15:0] len_full;
    logic [9:0]  count_inc;
    logic        mem_we;
    logic [7:0]  ram_rd_data;
    fpc_out_t    s1_result;

    // Handshake and stage flow.
    assign s2_free    = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && s2_free;
    assign in_stall   = s1_valid_reg && !s2_free;
    assign in_acc     = in_valid && !in_stall;
    assign is_rx      = in_acc && (in_data.action == ACT_RX);
    assign is_read    = in_acc && (in_data.action == ACT_READ);

    // Effective length limit is the smaller of the register and the store depth.
    assign limit = (17'(max_len_reg) > 17'(MAX_PAYLOAD)) ? 17'(MAX_PAYLOAD)
                                                         : 17'(max_len_reg);
    assign len_full  = {in_data.rx_byte, len_reg[7:0]};
    assign count_inc = 10'(count_reg) + 10'd1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RST;
            max_len_reg    <= MAX_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_BYTE: start_byte_reg <= cfg_data[7:0];
                CFG_MAX_LEN:    max_len_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Phase machine: one line byte per accepted receive request.
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        len_next     = len_reg;
        crc_next     = crc_reg;
        crc_low_next = crc_low_reg;
        hdr_next     = hdr_reg;
        good_frame   = 1'b0;
        mem_we       = 1'b0;
        if (is_rx)
        begin
            if (in_data.rx_byte == start_byte_reg)
            begin
                // A start byte resynchronizes from any phase.
                phase_next = PH_HEADER;
                count_next = '0;
                len_next   = '0;
                crc_next   = CRC_INIT;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        crc_next = crc16_step(crc_reg, in_data.rx_byte);
                        if (count_reg < 9'(HDR_BYTES))
                        begin
                            hdr_next[count_reg[1:0]] = in_data.rx_byte;
                            count_next = count_inc[8:0];
                        end
                        else if (count_reg == 9'(HDR_BYTES))
                        begin
                            len_next   = {8'h00, in_data.rx_byte};
                            count_next = count_inc[8:0];
                        end
                        else if (17'(len_full) > limit)
                        begin
                            phase_next = PH_IDLE;
                            count_next = '0;
                            len_next   = '0;
                        end
                        else
                        begin
                            len_next   = len_full;
                            count_next = '0;
                            phase_next = (len_full == 16'd0) ? PH_CRC : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        crc_next = crc16_step(crc_reg, in_data.rx_byte);
                        mem_we   = 32'(count_reg) < MAX_PAYLOAD;
                        if (16'(count_inc) >= len_reg)
                        begin
                            count_next = '0;
                            phase_next = PH_CRC;
                        end
                        else
                        begin
                            count_next = count_inc[8:0];
                        end
                    end
                    PH_CRC:
                    begin
                        if (count_reg == 9'd0)
                        begin
                            crc_low_next = in_data.rx_byte;
                            count_next   = 9'd1;
                        end
                        else
                        begin
                            good_frame = ({in_data.rx_byte, crc_low_reg} == crc_reg);
                            phase_next = PH_IDLE;
                            count_next = '0;
                            len_next   = '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            len_reg     <= '0;
            crc_reg     <= CRC_INIT;
            crc_low_reg <= '0;
            for (int i = 0; i < HDR_BYTES; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            len_reg     <= len_next;
            crc_reg     <= crc_next;
            crc_low_reg <= crc_low_next;
            hdr_reg     <= hdr_next;
        end
    end

    // Payload store. A write and a read never fall in the same cycle, since each
    // request is either a line byte or a read, so a later read sees the written byte.
    fpc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD),
        .ADDR_W(ADDR_W)
    ) u_payload_ram (
        .clk    (clk),
        .wr_en  (mem_we),
        .wr_addr(ADDR_W'(count_reg)),
        .wr_data(in_data.rx_byte),
        .rd_en  (is_read),
        .rd_addr(ADDR_W'(in_data.read_index)),
        .rd_data(ram_rd_data)
    );

    // Result stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= is_read || good_frame;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_kind_reg     <= is_read ? KIND_READ : KIND_FRAME;
            s1_in_range_reg <= 32'(in_data.read_index) < MAX_PAYLOAD;
            s1_dest_reg     <= is_read ? 8'd0 : hdr_reg[0];
            s1_src_reg      <= is_read ? 8'd0 : hdr_reg[1];
            s1_func_reg     <= is_read ? 8'd0 : hdr_reg[2];
            s1_len_reg      <= is_read ? 9'd0 : len_reg[8:0];
        end
    end

    // Assemble the result with the RAM read data.
    always_comb
    begin
        s1_result.kind          = s1_kind_reg;
        s1_result.dest_addr     = s1_dest_reg;
        s1_result.source_id     = s1_src_reg;
        s1_result.function_code = s1_func_reg;
        s1_result.payload_len   = s1_len_reg;
        s1_result.read_data     = ((s1_kind_reg == KIND_READ) && s1_in_range_reg)
                                  ? ram_rd_data : 8'd0;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_data_reg <= s1_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
